@@ rtl/core/tqe_pkg.sv @@
package tqe_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_SETUP  = 3'd1;
	localparam logic [2:0] ACT_ARM    = 3'd2;
	localparam logic [2:0] ACT_CANCEL = 3'd3;

	localparam logic [1:0] KIND_FIRED      = 2'd0;
	localparam logic [1:0] KIND_DONE       = 2'd1;
	localparam logic [1:0] KIND_CANCEL_OK  = 2'd2;
	localparam logic [1:0] KIND_CANCEL_NAK = 2'd3;

	localparam int IN_BITS  = 72;
	localparam int OUT_BITS = 40;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic do_op;
		logic tick_inc;
		logic scan_step;
		logic fire;
		logic emit_mid;
		logic emit_final;
	} tqe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic out_free;
		logic scan_last;
		logic best_vld;
		logic pend_vld;
	} tqe_stat_t;

endpackage

@@ rtl/core/tqe_ctrl.sv @@
module tqe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tqe_pkg::tqe_stat_t st,
	output tqe_pkg::tqe_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (st.is_tick) begin
					cmd.tick_inc = 1'b1;
					state_d      = ST_SCAN;
				end else if (st.out_free) begin
					cmd.do_op = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (st.best_vld) begin
					// previous firing goes out once another one is known
					if (!st.pend_vld || st.out_free) begin
						cmd.emit_mid = st.pend_vld;
						cmd.fire     = 1'b1;
						state_d      = ST_SCAN;
					end
				end else if (st.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ rtl/core/tqe_dp.sv @@
module tqe_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tqe_pkg::IN_BITS-1:0]  in_data,
	input  tqe_pkg::tqe_cmd_t            cmd,
	output tqe_pkg::tqe_stat_t           st,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tqe_pkg::OUT_BITS-1:0] out_data,
	output logic                         out_last
);

	localparam int SW = tqe_pkg::SLOT_W;

	logic [31:0] tick_q, arm_cnt_q;
	logic [tqe_pkg::SLOTS-1:0] active_q, done_q;
	logic [31:0] expiry_q [tqe_pkg::SLOTS];
	logic [31:0] period_q [tqe_pkg::SLOTS];
	logic [31:0] stamp_q  [tqe_pkg::SLOTS];

	logic [2:0]  act_q;
	logic [3:0]  slot_q;
	logic [31:0] delay_q, pin_q;

	logic [SW-1:0] idx_q, best_q, pend_q;
	logic [31:0]   best_d_q, best_age_q, best_per_q;
	logic          best_vld_q, pend_vld_q;

	logic          out_valid_q, out_last_q;
	logic [1:0]    out_kind_q;
	logic [3:0]    out_slot_q;
	logic [31:0]   out_time_q;

	logic          ok;
	logic [SW-1:0] sidx;
	logic [31:0]   d, age, cur_per;
	logic          due, better;

	assign ok   = (32'(slot_q) < tqe_pkg::SLOTS);
	assign sidx = SW'(slot_q);

	assign d       = expiry_q[idx_q] - tick_q;
	assign age     = arm_cnt_q - stamp_q[idx_q];
	assign cur_per = period_q[idx_q];
	assign due     = active_q[idx_q] && !done_q[idx_q] && ($signed(d) <= 0);
	assign better  = !best_vld_q || ($signed(d) < $signed(best_d_q)) ||
		((d == best_d_q) && (age > best_age_q));

	assign st.is_tick   = (act_q == tqe_pkg::ACT_TICK);
	assign st.out_free  = !out_valid_q || out_ready;
	assign st.scan_last = (idx_q == SW'(tqe_pkg::SLOTS - 1));
	assign st.best_vld  = best_vld_q;
	assign st.pend_vld  = pend_vld_q;

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_data  = {2'b00, out_time_q, out_slot_q, out_kind_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= in_data[2:0];
			slot_q  <= in_data[6:3];
			delay_q <= in_data[38:7];
			pin_q   <= in_data[70:39];
		end
		if (cmd.scan_step && due && better) begin
			best_q     <= idx_q;
			best_d_q   <= d;
			best_age_q <= age;
			best_per_q <= cur_per;
		end
		if (cmd.fire)
			pend_q <= best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			arm_cnt_q   <= '0;
			active_q    <= '0;
			done_q      <= '0;
			idx_q       <= '0;
			best_vld_q  <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_kind_q  <= '0;
			out_slot_q  <= '0;
			out_time_q  <= '0;
			for (int i = 0; i < tqe_pkg::SLOTS; i++) begin
				expiry_q[i] <= '0;
				period_q[i] <= '0;
				stamp_q[i]  <= '0;
			end
		end else begin
			// result register: loaded by any emit, cleared when taken
			if (cmd.do_op || cmd.emit_mid || cmd.emit_final) begin
				out_valid_q <= 1'b1;
				out_time_q  <= tick_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.do_op) begin
				out_last_q <= 1'b1;
				case (act_q)
					tqe_pkg::ACT_SETUP: begin
						out_kind_q <= tqe_pkg::KIND_DONE;
						out_slot_q <= slot_q;
						if (ok) begin
							period_q[sidx] <= pin_q;
							expiry_q[sidx] <= '0;
							active_q[sidx] <= 1'b0;
						end
					end
					tqe_pkg::ACT_ARM: begin
						out_kind_q <= tqe_pkg::KIND_DONE;
						out_slot_q <= slot_q;
						if (ok) begin
							expiry_q[sidx] <= tick_q + ((delay_q != '0) ? delay_q : 32'd1);
							active_q[sidx] <= 1'b1;
							stamp_q[sidx]  <= arm_cnt_q;
							arm_cnt_q      <= arm_cnt_q + 32'd1;
						end
					end
					tqe_pkg::ACT_CANCEL: begin
						out_slot_q <= slot_q;
						if (ok && active_q[sidx]) begin
							active_q[sidx] <= 1'b0;
							out_kind_q     <= tqe_pkg::KIND_CANCEL_OK;
						end else begin
							out_kind_q <= tqe_pkg::KIND_CANCEL_NAK;
						end
					end
					default: begin
						out_kind_q <= tqe_pkg::KIND_DONE;
						out_slot_q <= '0;
					end
				endcase
			end

			if (cmd.tick_inc) begin
				tick_q     <= tick_q + 32'd1;
				done_q     <= '0;
				idx_q      <= '0;
				best_vld_q <= 1'b0;
				pend_vld_q <= 1'b0;
			end

			if (cmd.scan_step) begin
				idx_q <= idx_q + SW'(1);
				if (due && better)
					best_vld_q <= 1'b1;
			end

			if (cmd.emit_mid) begin
				out_last_q <= 1'b0;
				out_kind_q <= tqe_pkg::KIND_FIRED;
				out_slot_q <= 4'(pend_q);
			end

			if (cmd.fire) begin
				done_q[best_q] <= 1'b1;
				if (best_per_q != '0) begin
					expiry_q[best_q] <= tick_q + best_per_q;
					stamp_q[best_q]  <= arm_cnt_q;
					arm_cnt_q        <= arm_cnt_q + 32'd1;
				end else begin
					active_q[best_q] <= 1'b0;
				end
				pend_vld_q <= 1'b1;
				best_vld_q <= 1'b0;
				idx_q      <= '0;
			end

			if (cmd.emit_final) begin
				out_last_q <= 1'b1;
				if (pend_vld_q) begin
					out_kind_q <= tqe_pkg::KIND_FIRED;
					out_slot_q <= 4'(pend_q);
				end else begin
					out_kind_q <= tqe_pkg::KIND_DONE;
					out_slot_q <= '0;
				end
			end
		end
	end

endmodule

@@ rtl/core/timer_queue_engine_top.sv @@
// timer queue engine: sixteen timer slots run against a 32-bit tick count.
// each input transaction carries one action (tick, setup, arm, cancel, read);
// setup, arm, cancel and read answer with one output transaction that is
// loaded into the output register once the action has executed and the
// output register is free, while a tick answers with one output transaction
// per slot that fires, in expiry order and ties oldest-armed first, or a
// single "nothing fired" transaction. a tick runs one full pass over the slot
// table per firing plus a final empty pass, one slot per cycle; output
// backpressure can hold it between passes and before its final result.
// one action is handled at a time; the output register holds a result while
// the next action is accepted. tlast marks the final result of each action.
module timer_queue_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], slot_id[6:3], arm_delay[38:7], period_ticks[70:39], pad
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// kind[1:0], fired_slot[5:2], time_now[37:6], pad
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	tqe_pkg::tqe_cmd_t  cmd;
	tqe_pkg::tqe_stat_t st;

	// sequencer: dispatch, slot scan passes, result release
	tqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// slot table, tick and arm counters, best-candidate tracking, output register
	tqe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	// one action in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an action is in flight");

	// cancel answers are always the only result of their action
	a_cancel_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == tqe_pkg::KIND_CANCEL_OK ||
		m_tdata[1:0] == tqe_pkg::KIND_CANCEL_NAK) |-> m_tlast)
		else $error("cancel result without tlast");

	// a non-final firing result is never emitted while idle
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_mid |-> !s_tready)
		else $error("firing result emitted outside a tick");

endmodule

@@ tb/sv/tb.sv @@
module tb;

	localparam logic [2:0] ACT_READ   = 3'd4;
	localparam logic [2:0] ACT_RSVD_5 = 3'd5;
	localparam logic [2:0] ACT_RSVD_6 = 3'd6;
	localparam logic [2:0] ACT_RSVD_7 = 3'd7;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [31:0] now;
		logic        last;
	} timer_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// action[2:0], slot_id[6:3], arm_delay[38:7], period_ticks[70:39], pad
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// kind[1:0], fired_slot[5:2], time_now[37:6], pad
	logic [39:0] m_tdata;
	logic        m_tlast;

	timer_queue_engine_top u_top (.*);

	// predictor state
	logic [31:0] tick_now = '0;
	logic [31:0] arm_seq = '0;
	logic        slot_on [16] = '{default: 1'b0};
	logic [31:0] slot_due [16] = '{default: 32'd0};
	logic [31:0] slot_every [16] = '{default: 32'd0};
	logic [31:0] slot_stamp [16] = '{default: 32'd0};

	logic [71:0]   pending_items[$];
	timer_result_t due_results[$];
	int  errors = 0;
	int  cycles = 0;
	int  stall_left;
	int  gap_left;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic timer_result_t make_result(logic [1:0] k, logic [3:0] s, logic l);
		timer_result_t r;
		r.kind = k;
		r.slot = s;
		r.now  = tick_now;
		r.last = l;
		return r;
	endfunction

	// advance the timer table by one accepted action and queue its results
	task automatic predict_action(logic [71:0] item);
		logic [2:0]  act;
		logic [3:0]  sid;
		logic [31:0] dly;
		logic [31:0] per;
		logic        fired_flag [16];
		int          n;
		int          best;
		logic signed [31:0] d;
		logic signed [31:0] best_d;
		logic [31:0] age;
		logic [31:0] best_age;
		act = item[2:0];
		sid = item[6:3];
		dly = item[38:7];
		per = item[70:39];
		case (act)
			tqe_pkg::ACT_TICK: begin
				tick_now = tick_now + 32'd1;
				for (int i = 0; i < 16; i++) fired_flag[i] = 1'b0;
				n = 0;
				forever begin
					best = -1;
					best_d = 0;
					best_age = 0;
					for (int i = 0; i < 16; i++) begin
						if (!slot_on[i] || fired_flag[i]) continue;
						d = $signed(slot_due[i] - tick_now);
						if (d > 0) continue;
						age = arm_seq - slot_stamp[i];
						if (best < 0 || d < best_d || (d == best_d && age > best_age)) begin
							best = i;
							best_d = d;
							best_age = age;
						end
					end
					if (best < 0) break;
					fired_flag[best] = 1'b1;
					if (slot_every[best] != 0) begin
						slot_due[best] = tick_now + slot_every[best];
						slot_stamp[best] = arm_seq;
						arm_seq = arm_seq + 32'd1;
					end else begin
						slot_on[best] = 1'b0;
					end
					due_results.push_back(make_result(tqe_pkg::KIND_FIRED, best[3:0], 1'b0));
					n++;
				end
				if (n == 0)
					due_results.push_back(make_result(tqe_pkg::KIND_DONE, 4'd0, 1'b1));
				else
					due_results[$].last = 1'b1;
			end
			tqe_pkg::ACT_SETUP: begin
				slot_every[sid] = per;
				slot_due[sid] = 0;
				slot_on[sid] = 1'b0;
				due_results.push_back(make_result(tqe_pkg::KIND_DONE, sid, 1'b1));
			end
			tqe_pkg::ACT_ARM: begin
				slot_due[sid] = tick_now + ((dly != 0) ? dly : 32'd1);
				slot_on[sid] = 1'b1;
				slot_stamp[sid] = arm_seq;
				arm_seq = arm_seq + 32'd1;
				due_results.push_back(make_result(tqe_pkg::KIND_DONE, sid, 1'b1));
			end
			tqe_pkg::ACT_CANCEL: begin
				if (slot_on[sid]) begin
					slot_on[sid] = 1'b0;
					due_results.push_back(make_result(tqe_pkg::KIND_CANCEL_OK, sid, 1'b1));
				end else begin
					due_results.push_back(make_result(tqe_pkg::KIND_CANCEL_NAK, sid, 1'b1));
				end
			end
			default: due_results.push_back(make_result(tqe_pkg::KIND_DONE, 4'd0, 1'b1));
		endcase
	endtask

	function automatic logic [71:0] pack_action(logic [2:0] act, logic [3:0] sid,
			logic [31:0] dly, logic [31:0] per);
		return {1'b0, per, dly, sid, act};
	endfunction

	// driver: one action at a time from the pending queue, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) predict_action(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || pending_items.size() == 0) begin
					s_tvalid <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_items.pop_front();
					gap_left <= pick_gap();
				end
			end
		end
	end

	// monitor: compare each output transaction against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		timer_result_t got;
		timer_result_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tdata[1:0];
				got.slot = m_tdata[5:2];
				got.now  = m_tdata[37:6];
				got.last = m_tlast;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d slot=%0d now=%0d last=%0d",
						$time, got.kind, got.slot, got.now, got.last);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected kind=%0d slot=%0d now=%0d last=%0d",
							$time, want.kind, want.slot, want.now, want.last);
						$display("%0t:          actual   kind=%0d slot=%0d now=%0d last=%0d",
							$time, got.kind, got.slot, got.now, got.last);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				m_tready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready   <= 1'b1;
				stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// cycle counter with a hard limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// stimulus: directed corners, then random action sequences
	initial begin
		int r;
		logic [2:0] act;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		pending_items.push_back(pack_action(tqe_pkg::ACT_TICK, 4'd0, 0, 0));
		pending_items.push_back(pack_action(ACT_READ, 4'd0, 0, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_CANCEL, 4'd15, 0, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_SETUP, 4'd3, 0, 32'd1));
		pending_items.push_back(pack_action(tqe_pkg::ACT_ARM, 4'd3, 32'd0, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_ARM, 4'd15, 32'd1, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_ARM, 4'd0, 32'd2, 0));
		// tie between slot 15 and slot 3 on expiry, arming order decides
		pending_items.push_back(pack_action(tqe_pkg::ACT_TICK, 4'd0, 0, 0));
		// periodic slot 3 with period 1 fires only once per tick
		pending_items.push_back(pack_action(tqe_pkg::ACT_TICK, 4'd0, 0, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_ARM, 4'd3, 32'd5, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_SETUP, 4'd3, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		pending_items.push_back(pack_action(tqe_pkg::ACT_CANCEL, 4'd3, 0, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_ARM, 4'd7, 32'hFFFF_FFFF, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_ARM, 4'd8, 32'h8000_0000, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_CANCEL, 4'd7, 0, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_CANCEL, 4'd8, 0, 0));
		pending_items.push_back(pack_action(ACT_RSVD_5, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_items.push_back(pack_action(ACT_RSVD_6, 4'd0, 0, 0));
		pending_items.push_back(pack_action(ACT_RSVD_7, 4'd15, 0, 0));
		pending_items.push_back(pack_action(tqe_pkg::ACT_TICK, 4'd15, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));

		// random part: mostly short delays and periods so slots keep firing
		for (int k = 0; k < 140; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45)      act = tqe_pkg::ACT_TICK;
			else if (r < 60) act = tqe_pkg::ACT_SETUP;
			else if (r < 82) act = tqe_pkg::ACT_ARM;
			else if (r < 92) act = tqe_pkg::ACT_CANCEL;
			else             act = 3'($urandom_range(4, 7));
			pending_items.push_back(pack_action(act, 4'($urandom_range(0, 15)),
				($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6),
				($urandom_range(0, 9) == 0) ? $urandom() :
				(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 4))));
		end

		wait (pending_items.size() == 0 && !s_tvalid && due_results.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && due_results.size() == 0 && !m_tvalid) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

@@ timer_queue_engine_top.f @@
rtl/core/tqe_pkg.sv
rtl/core/tqe_ctrl.sv
rtl/core/tqe_dp.sv
rtl/core/timer_queue_engine_top.sv
tb/sv/tb.sv
